[src/uds_dtc_read_isotp_client_macros.svh]
// Assertion macros shared by the fault-code read client RTL.
// Included by every module that carries concurrent assertions.
`ifndef UDS_DTC_READ_ISOTP_CLIENT_MACROS_SVH
`define UDS_DTC_READ_ISOTP_CLIENT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define UDT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define UDT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/udsdtc_pkg.sv]
// Types, codes and constants of the fault-code read client.
// No dependencies; used by every module of the block except udsdtc_ram.
`timescale 1ns / 1ps
`default_nettype none

package udsdtc_pkg;

    localparam int RX_BYTES_DEF    = 128;
    localparam int MAX_RECORDS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_FRAME  = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_REINIT = 2'd3;

    localparam logic [1:0] CFG_REQUEST_ID  = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_ID = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_MS  = 2'd2;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WSESSION = 3'd1;
    localparam logic [2:0] PH_WREAD    = 3'd2;
    localparam logic [2:0] PH_WCF      = 3'd3;
    localparam logic [2:0] PH_COMPLETE = 3'd4;
    localparam logic [2:0] PH_ERROR    = 3'd5;

    localparam logic [3:0] FT_SINGLE = 4'h0;
    localparam logic [3:0] FT_FIRST  = 4'h1;
    localparam logic [3:0] FT_CONSEC = 4'h2;

    localparam logic [7:0] SID_NEGATIVE    = 8'h7F;
    localparam logic [7:0] SID_SESSION_POS = 8'h50;
    localparam logic [7:0] SID_READ_POS    = 8'h59;
    localparam logic [7:0] SESSION_EXT     = 8'h03;
    localparam logic [7:0] SUBFN_BY_MASK   = 8'h02;

    localparam logic [3:0]  TX_SESSION_DLC  = 4'd3;
    localparam logic [63:0] TX_SESSION_DATA = 64'h0000_0000_0003_1002;
    localparam logic [3:0]  TX_READ_DLC     = 4'd4;
    localparam logic [63:0] TX_READ_DATA    = 64'h0000_0000_FF02_1903;
    localparam logic [3:0]  TX_FLOW_DLC     = 4'd3;
    localparam logic [63:0] TX_FLOW_DATA    = 64'h0000_0000_0000_0030;

    localparam logic [31:0] TIMEOUT_RESET = 32'd2000;
    localparam logic [2:0]  FF_MAX_BYTES  = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now_ms;
        logic [28:0] frame_id;
        logic        frame_extended;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [2:0]  fsm_state;
        logic        tx_valid;
        logic [3:0]  tx_dlc;
        logic [63:0] tx_data;
        logic [4:0]  code_count;
        logic        record_valid;
        logic [23:0] fault_code;
        logic [7:0]  fault_status;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        id_match;
        logic        negative;
        logic        session_ok;
        logic        sf_ok;
        logic [3:0]  ftype;
        logic [3:0]  low;
        logic [11:0] ff_total;
        logic [2:0]  sf_count;
        logic [2:0]  ff_count;
        logic [2:0]  cf_avail;
        logic [63:0] data;
        logic [31:0] now_ms;
    } cmd_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } queue_status_t;

endpackage

`default_nettype wire

[src/uds_dtc_read_isotp_client.sv]
// Top level of the fault-code read client: configuration registers,
// front end, command queue and back end. Depends on udsdtc_pkg and all submodules.
//
//   channel  | direction | handshake           | payload
//   s_       | in        | s_valid / s_ready   | udsdtc_pkg::in_item_t
//   m_       | out       | m_valid / m_ready   | udsdtc_pkg::out_item_t, 1 to 17 per input
//   cfg_     | in        | cfg_valid/cfg_ready | cfg_index (2), cfg_data (32)
//
// Each input transaction runs through the back end states idle, execute, write
// (payload store bytes, 0 to 7), finish and status; each fault record adds a read
// state, fetching its four bytes via the registered read port, and an output state.
// The front end accepts while the two-entry command queue has room.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled m_ready holds the back end in its output state.
`timescale 1ns / 1ps
`default_nettype none

module uds_dtc_read_isotp_client #(
    parameter int RX_BYTES    = udsdtc_pkg::RX_BYTES_DEF,
    parameter int MAX_RECORDS = udsdtc_pkg::MAX_RECORDS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire udsdtc_pkg::in_item_t  s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output udsdtc_pkg::out_item_t      m_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);

    logic [28:0] resp_filter_reg;
    logic [31:0] timeout_reg;

    udsdtc_pkg::queue_status_t q_status;
    udsdtc_pkg::cmd_t          push_cmd;
    udsdtc_pkg::cmd_t          q_head;
    logic                      push;
    logic                      pop;

    assign cfg_ready = 1'b1;

    // The request identifier is carried by the transmit side; only the
    // response filter and the timeout are held here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_filter_reg <= '0;
            timeout_reg     <= udsdtc_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == udsdtc_pkg::CFG_RESPONSE_ID) begin
                resp_filter_reg <= cfg_data[28:0];
            end
            if (cfg_index == udsdtc_pkg::CFG_TIMEOUT_MS) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    udsdtc_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .resp_filter_id (resp_filter_reg),
        .q_status       (q_status),
        .push           (push),
        .cmd            (push_cmd)
    );

    udsdtc_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .status   (q_status),
        .head     (q_head)
    );

    udsdtc_back #(
        .RX_BYTES    (RX_BYTES),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .q_head        (q_head),
        .q_pop         (pop),
        .wait_limit_ms (timeout_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item)
    );

endmodule

`default_nettype wire

[src/udsdtc_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module udsdtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[src/udsdtc_front.sv]
// Front end: accepts input transactions and classifies received frames.
// Depends on udsdtc_pkg; feeds udsdtc_cmd_queue.
`timescale 1ns / 1ps
`default_nettype none

module udsdtc_front (
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire udsdtc_pkg::in_item_t  s_item,
    input  wire logic [28:0]           resp_filter_id,
    input  wire udsdtc_pkg::queue_status_t q_status,
    output logic                       push,
    output udsdtc_pkg::cmd_t           cmd
);

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [3:0] dlc8;
    logic [2:0] avail;
    logic [3:0] low;
    logic [11:0] total;

    assign b0    = s_item.frame_data[7:0];
    assign b1    = s_item.frame_data[15:8];
    assign b2    = s_item.frame_data[23:16];
    assign low   = b0[3:0];
    assign total = {low, b1};
    assign dlc8  = (s_item.frame_dlc > 4'd8) ? 4'd8 : s_item.frame_dlc;
    assign avail = (dlc8 == 4'd0) ? 3'd0 : 3'(dlc8 - 4'd1);

    assign s_ready = q_status.not_full;
    assign push    = s_valid && q_status.not_full;

    always_comb begin
        cmd            = '0;
        cmd.mode       = s_item.mode;
        cmd.id_match   = s_item.frame_extended && (s_item.frame_id == resp_filter_id);
        cmd.negative   = (s_item.frame_dlc >= 4'd3) && (b1 == udsdtc_pkg::SID_NEGATIVE);
        cmd.session_ok = (s_item.frame_dlc >= 4'd3) && (b1 == udsdtc_pkg::SID_SESSION_POS)
                         && (b2 == udsdtc_pkg::SESSION_EXT);
        cmd.sf_ok      = (low >= 4'd3) && (s_item.frame_dlc >= 4'd4)
                         && (b1 == udsdtc_pkg::SID_READ_POS)
                         && (b2 == udsdtc_pkg::SUBFN_BY_MASK);
        cmd.ftype      = b0[7:4];
        cmd.low        = low;
        cmd.ff_total   = total;
        cmd.sf_count   = (low < 4'(avail)) ? low[2:0] : avail;
        cmd.ff_count   = (total < 12'(udsdtc_pkg::FF_MAX_BYTES)) ? total[2:0]
                                                                  : udsdtc_pkg::FF_MAX_BYTES;
        cmd.cf_avail   = avail;
        cmd.data       = s_item.frame_data;
        cmd.now_ms     = s_item.now_ms;
    end

endmodule

`default_nettype wire

[src/udsdtc_cmd_queue.sv]
// Short command queue between the front end and the back end.
// Depends on udsdtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module udsdtc_cmd_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire udsdtc_pkg::cmd_t      push_cmd,
    input  wire logic                  pop,
    output udsdtc_pkg::queue_status_t  status,
    output udsdtc_pkg::cmd_t           head
);

    localparam int DEPTH = udsdtc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    udsdtc_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.not_full  = (count_reg != CNTW'(DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign do_push = push && status.not_full;
    assign do_pop  = pop && status.not_empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNTW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[src/udsdtc_back.sv]
// Back end: session state, payload store, record parsing and result output.
// Depends on udsdtc_pkg, udsdtc_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "uds_dtc_read_isotp_client_macros.svh"

module udsdtc_back #(
    parameter int RX_BYTES    = udsdtc_pkg::RX_BYTES_DEF,
    parameter int MAX_RECORDS = udsdtc_pkg::MAX_RECORDS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire udsdtc_pkg::queue_status_t q_status,
    input  wire udsdtc_pkg::cmd_t      q_head,
    output logic                       q_pop,
    input  wire logic [31:0]           wait_limit_ms,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output udsdtc_pkg::out_item_t      m_item
);

    localparam int AW = $clog2(RX_BYTES);
    localparam int CW = $clog2(RX_BYTES + 1);
    localparam int RW = $clog2(MAX_RECORDS + 1);
    localparam int QW = (CW > RW) ? CW : RW;

    typedef enum logic [2:0] {
        B_IDLE, B_EXEC, B_WRITE, B_FINISH, B_STATUS, B_READ, B_REC
    } seq_t;

    typedef enum logic [1:0] {
        FIN_NONE, FIN_DONE, FIN_CHECK
    } fin_t;

    seq_t             seq_reg, seq_next;
    fin_t             fin_reg, fin_next;
    udsdtc_pkg::cmd_t cmd_reg, cmd_next;
    logic [2:0]       phase_reg, phase_next;
    logic [31:0]      since_reg, since_next;
    logic [CW-1:0]    br_reg, br_next;
    logic [CW-1:0]    be_reg, be_next;
    logic [3:0]       ns_reg, ns_next;
    logic [RW-1:0]    rt_reg, rt_next;
    logic             done_reg, done_next;
    logic             txv_reg, txv_next;
    logic [3:0]       txdlc_reg, txdlc_next;
    logic [63:0]      txdata_reg, txdata_next;
    logic [2:0]       wr_src_reg, wr_src_next;
    logic [2:0]       wr_left_reg, wr_left_next;
    logic [RW-1:0]    rec_idx_reg, rec_idx_next;
    logic [AW-1:0]    rec_base_reg, rec_base_next;
    logic [2:0]       rsub_reg, rsub_next;
    logic [31:0]      rec_word_reg, rec_word_next;
    logic             m_valid_reg, m_valid_next;
    udsdtc_pkg::out_item_t m_item_reg, m_item_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          out_free;
    logic [31:0]   elapsed;
    logic [CW-1:0] total_c;
    logic [CW-1:0] room;
    logic [2:0]    cf_count;
    logic [CW-1:0] rec_q;
    logic [RW-1:0] rec_n;
    logic          waiting;

    assign out_free  = !m_valid_reg || m_ready;
    assign elapsed   = cmd_reg.now_ms - since_reg;
    assign waiting   = (phase_reg == udsdtc_pkg::PH_WSESSION)
                       || (phase_reg == udsdtc_pkg::PH_WREAD)
                       || (phase_reg == udsdtc_pkg::PH_WCF);
    assign total_c   = (cmd_reg.ff_total > 12'(RX_BYTES)) ? CW'(RX_BYTES)
                                                          : CW'(cmd_reg.ff_total);
    assign room      = be_reg - br_reg;
    assign cf_count  = (CW'(cmd_reg.cf_avail) < room) ? cmd_reg.cf_avail : room[2:0];
    assign rec_q     = (br_reg >= CW'(3)) ? ((br_reg - CW'(3)) >> 2) : '0;
    assign rec_n     = (QW'(rec_q) > QW'(MAX_RECORDS)) ? RW'(MAX_RECORDS) : RW'(rec_q);

    assign ram_we    = (seq_reg == B_WRITE) && (wr_left_reg != 3'd0);
    assign ram_waddr = br_reg[AW-1:0];
    assign ram_wdata = cmd_reg.data[8*wr_src_reg +: 8];
    assign ram_raddr = rec_base_reg + AW'(rsub_reg[1:0]);

    assign q_pop   = (seq_reg == B_IDLE) && q_status.not_empty;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    udsdtc_ram #(
        .WIDTH(8),
        .DEPTH(RX_BYTES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        seq_next      = seq_reg;
        fin_next      = fin_reg;
        cmd_next      = cmd_reg;
        phase_next    = phase_reg;
        since_next    = since_reg;
        br_next       = br_reg;
        be_next       = be_reg;
        ns_next       = ns_reg;
        rt_next       = rt_reg;
        done_next     = done_reg;
        txv_next      = txv_reg;
        txdlc_next    = txdlc_reg;
        txdata_next   = txdata_reg;
        wr_src_next   = wr_src_reg;
        wr_left_next  = wr_left_reg;
        rec_idx_next  = rec_idx_reg;
        rec_base_next = rec_base_reg;
        rsub_next     = rsub_reg;
        rec_word_next = rec_word_reg;
        m_item_next   = m_item_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;

        unique case (seq_reg)
            B_IDLE: begin
                if (q_status.not_empty) begin
                    cmd_next = q_head;
                    seq_next = B_EXEC;
                end
            end
            B_EXEC: begin
                txv_next     = 1'b0;
                txdlc_next   = '0;
                txdata_next  = '0;
                wr_left_next = '0;
                fin_next     = FIN_NONE;
                seq_next     = B_WRITE;
                unique case (cmd_reg.mode)
                    udsdtc_pkg::MODE_START: begin
                        if (phase_reg == udsdtc_pkg::PH_IDLE) begin
                            txv_next    = 1'b1;
                            txdlc_next  = udsdtc_pkg::TX_SESSION_DLC;
                            txdata_next = udsdtc_pkg::TX_SESSION_DATA;
                            phase_next  = udsdtc_pkg::PH_WSESSION;
                            since_next  = cmd_reg.now_ms;
                            rt_next     = '0;
                            br_next     = '0;
                            be_next     = '0;
                            ns_next     = 4'd1;
                        end
                    end
                    udsdtc_pkg::MODE_FRAME: begin
                        if (cmd_reg.id_match) begin
                            if (cmd_reg.negative) begin
                                phase_next = udsdtc_pkg::PH_ERROR;
                            end else if (phase_reg == udsdtc_pkg::PH_WSESSION
                                         && cmd_reg.session_ok) begin
                                txv_next    = 1'b1;
                                txdlc_next  = udsdtc_pkg::TX_READ_DLC;
                                txdata_next = udsdtc_pkg::TX_READ_DATA;
                                phase_next  = udsdtc_pkg::PH_WREAD;
                                since_next  = cmd_reg.now_ms;
                            end else if (phase_reg == udsdtc_pkg::PH_WREAD
                                         && cmd_reg.ftype == udsdtc_pkg::FT_SINGLE) begin
                                if (cmd_reg.sf_ok) begin
                                    br_next      = '0;
                                    wr_src_next  = 3'd1;
                                    wr_left_next = cmd_reg.sf_count;
                                    fin_next     = FIN_DONE;
                                end
                            end else if (phase_reg == udsdtc_pkg::PH_WREAD
                                         && cmd_reg.ftype == udsdtc_pkg::FT_FIRST) begin
                                be_next      = total_c;
                                br_next      = '0;
                                ns_next      = 4'd1;
                                wr_src_next  = 3'd2;
                                wr_left_next = cmd_reg.ff_count;
                                txv_next     = 1'b1;
                                txdlc_next   = udsdtc_pkg::TX_FLOW_DLC;
                                txdata_next  = udsdtc_pkg::TX_FLOW_DATA;
                                phase_next   = udsdtc_pkg::PH_WCF;
                                since_next   = cmd_reg.now_ms;
                            end else if (phase_reg == udsdtc_pkg::PH_WCF
                                         && cmd_reg.ftype == udsdtc_pkg::FT_CONSEC) begin
                                if (cmd_reg.low != ns_reg) begin
                                    phase_next = udsdtc_pkg::PH_ERROR;
                                end else begin
                                    ns_next      = ns_reg + 4'd1;
                                    wr_src_next  = 3'd1;
                                    wr_left_next = cf_count;
                                    since_next   = cmd_reg.now_ms;
                                    fin_next     = FIN_CHECK;
                                end
                            end
                        end
                    end
                    udsdtc_pkg::MODE_TICK: begin
                        if (waiting && (elapsed > wait_limit_ms)) begin
                            phase_next = udsdtc_pkg::PH_ERROR;
                        end
                    end
                    udsdtc_pkg::MODE_REINIT: begin
                        phase_next = udsdtc_pkg::PH_IDLE;
                        since_next = '0;
                        br_next    = '0;
                        be_next    = '0;
                        ns_next    = '0;
                        rt_next    = '0;
                    end
                endcase
            end
            B_WRITE: begin
                if (wr_left_reg != 3'd0) begin
                    br_next      = br_reg + CW'(1);
                    wr_src_next  = wr_src_reg + 3'd1;
                    wr_left_next = wr_left_reg - 3'd1;
                end else begin
                    seq_next = B_FINISH;
                end
            end
            B_FINISH: begin
                done_next = 1'b0;
                if (fin_reg == FIN_DONE || (fin_reg == FIN_CHECK && br_reg >= be_reg)) begin
                    phase_next = udsdtc_pkg::PH_COMPLETE;
                    rt_next    = rec_n;
                    done_next  = 1'b1;
                end
                seq_next = B_STATUS;
            end
            B_STATUS: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_item_next              = '0;
                    m_item_next.accepted     = txv_reg;
                    m_item_next.fsm_state    = phase_reg;
                    m_item_next.tx_valid     = txv_reg;
                    m_item_next.tx_dlc       = txdlc_reg;
                    m_item_next.tx_data      = txdata_reg;
                    m_item_next.code_count   = 5'(rt_reg);
                    m_item_next.last         = !(done_reg && rt_reg != '0);
                    if (done_reg && rt_reg != '0) begin
                        rec_idx_next  = '0;
                        rec_base_next = AW'(3);
                        rsub_next     = '0;
                        seq_next      = B_READ;
                    end else begin
                        seq_next = B_IDLE;
                    end
                end
            end
            B_READ: begin
                if (rsub_reg != 3'd0) begin
                    rec_word_next = {rec_word_reg[23:0], ram_rdata};
                end
                if (rsub_reg == 3'd4) begin
                    seq_next = B_REC;
                end else begin
                    rsub_next = rsub_reg + 3'd1;
                end
            end
            B_REC: begin
                if (out_free) begin
                    m_valid_next              = 1'b1;
                    m_item_next               = '0;
                    m_item_next.fsm_state     = phase_reg;
                    m_item_next.code_count    = 5'(rt_reg);
                    m_item_next.record_valid  = 1'b1;
                    m_item_next.fault_code    = rec_word_reg[31:8];
                    m_item_next.fault_status  = rec_word_reg[7:0];
                    m_item_next.last          = (rec_idx_reg + RW'(1) == rt_reg);
                    if (rec_idx_reg + RW'(1) == rt_reg) begin
                        seq_next = B_IDLE;
                    end else begin
                        rec_idx_next  = rec_idx_reg + RW'(1);
                        rec_base_next = rec_base_reg + AW'(4);
                        rsub_next     = '0;
                        seq_next      = B_READ;
                    end
                end
            end
            default: begin
                seq_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= B_IDLE;
            fin_reg     <= FIN_NONE;
            phase_reg   <= udsdtc_pkg::PH_IDLE;
            since_reg   <= '0;
            br_reg      <= '0;
            be_reg      <= '0;
            ns_reg      <= '0;
            rt_reg      <= '0;
            done_reg    <= 1'b0;
            rec_idx_reg <= '0;
            rsub_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            seq_reg     <= seq_next;
            fin_reg     <= fin_next;
            phase_reg   <= phase_next;
            since_reg   <= since_next;
            br_reg      <= br_next;
            be_reg      <= be_next;
            ns_reg      <= ns_next;
            rt_reg      <= rt_next;
            done_reg    <= done_next;
            rec_idx_reg <= rec_idx_next;
            rsub_reg    <= rsub_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        txv_reg      <= txv_next;
        txdlc_reg    <= txdlc_next;
        txdata_reg   <= txdata_next;
        wr_src_reg   <= wr_src_next;
        wr_left_reg  <= wr_left_next;
        rec_base_reg <= rec_base_next;
        rec_word_reg <= rec_word_next;
        m_item_reg   <= m_item_next;
    end

    `UDT_ASSERT_IMP(a_br_bound, aclk, aresetn, 1'b1, br_reg <= CW'(RX_BYTES))
    `UDT_ASSERT_IMP(a_cf_room, aclk, aresetn, phase_reg == udsdtc_pkg::PH_WCF,
                    br_reg <= be_reg)
    `UDT_ASSERT_IMP(a_rec_in_range, aclk, aresetn, seq_reg == B_REC,
                    phase_reg == udsdtc_pkg::PH_COMPLETE && rec_idx_reg < rt_reg)
    `UDT_ASSERT_IMP(a_done_complete, aclk, aresetn, seq_reg == B_STATUS && done_reg,
                    phase_reg == udsdtc_pkg::PH_COMPLETE)

endmodule

`default_nettype wire

[tb/dtc_read_checker.sv]
`timescale 1ns / 1ps
// Result checker for the fault-code read client: follows the input, result and
// register-write channels, predicts every result and compares it. Needs udsdtc_pkg.

module dtc_read_checker
    import udsdtc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    logic [28:0] resp_filter_reg;
    logic [31:0] timeout_reg;

    logic [2:0]  client_phase;
    logic [31:0] since_ms;
    int          rx_count;
    int          rx_total;
    logic [3:0]  cf_seq;
    int          record_count;
    logic [7:0]  rx_store [RX_BYTES_DEF];

    out_item_t   results_due [$];

    task automatic clear_transfer();
        client_phase = PH_IDLE;
        since_ms     = '0;
        rx_count     = 0;
        rx_total     = 0;
        cf_seq       = '0;
        record_count = 0;
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (rx_count < RX_BYTES_DEF) begin
            rx_store[rx_count] = b;
            rx_count++;
        end
    endtask

    task automatic tally_records();
        record_count = (rx_count >= 7) ? (rx_count - 3) / 4 : 0;
        if (record_count > MAX_RECORDS_DEF) record_count = MAX_RECORDS_DEF;
    endtask

    task automatic predict_client_step(input in_item_t it);
        logic [7:0]  b [8];
        logic [3:0]  ftype;
        logic [3:0]  fnib;
        logic [31:0] elapsed;
        logic        tx_v;
        logic [3:0]  tx_len;
        logic [63:0] tx_bytes;
        bit          done;
        int          dlc8;
        int          total;
        int          k;
        int          off;
        out_item_t   r;
        for (k = 0; k < 8; k++) b[k] = it.frame_data[8*k +: 8];
        ftype    = b[0][7:4];
        fnib     = b[0][3:0];
        dlc8     = (it.frame_dlc > 4'd8) ? 8 : int'(it.frame_dlc);
        tx_v     = 1'b0;
        tx_len   = '0;
        tx_bytes = '0;
        done     = 1'b0;
        case (it.mode)
            MODE_START: begin
                if (client_phase == PH_IDLE) begin
                    tx_v         = 1'b1;
                    tx_len       = TX_SESSION_DLC;
                    tx_bytes     = TX_SESSION_DATA;
                    client_phase = PH_WSESSION;
                    since_ms     = it.now_ms;
                    record_count = 0;
                    rx_count     = 0;
                    rx_total     = 0;
                    cf_seq       = 4'd1;
                end
            end
            MODE_FRAME: begin
                if (it.frame_extended && it.frame_id == resp_filter_reg) begin
                    if (it.frame_dlc >= 4'd3 && b[1] == SID_NEGATIVE) begin
                        client_phase = PH_ERROR;
                    end else if (client_phase == PH_WSESSION && it.frame_dlc >= 4'd3 &&
                                 b[1] == SID_SESSION_POS && b[2] == SESSION_EXT) begin
                        tx_v         = 1'b1;
                        tx_len       = TX_READ_DLC;
                        tx_bytes     = TX_READ_DATA;
                        client_phase = PH_WREAD;
                        since_ms     = it.now_ms;
                    end else if (client_phase == PH_WREAD && ftype == FT_SINGLE) begin
                        if (fnib >= 4'd3 && it.frame_dlc >= 4'd4 && b[1] == SID_READ_POS &&
                            b[2] == SUBFN_BY_MASK) begin
                            rx_count = 0;
                            for (k = 0; k < int'(fnib) && k + 1 < dlc8; k++) keep_byte(b[k + 1]);
                            tally_records();
                            client_phase = PH_COMPLETE;
                            done         = 1'b1;
                        end
                    end else if (client_phase == PH_WREAD && ftype == FT_FIRST) begin
                        total = int'({fnib, b[1]});
                        if (total > RX_BYTES_DEF) total = RX_BYTES_DEF;
                        rx_total = total;
                        rx_count = 0;
                        cf_seq   = 4'd1;
                        for (k = 0; k < total && k < 6; k++) keep_byte(b[2 + k]);
                        tx_v         = 1'b1;
                        tx_len       = TX_FLOW_DLC;
                        tx_bytes     = TX_FLOW_DATA;
                        client_phase = PH_WCF;
                        since_ms     = it.now_ms;
                    end else if (client_phase == PH_WCF && ftype == FT_CONSEC) begin
                        if (fnib != cf_seq) begin
                            client_phase = PH_ERROR;
                        end else begin
                            cf_seq = cf_seq + 4'd1;
                            for (k = 1; k < dlc8 && rx_count < rx_total; k++) keep_byte(b[k]);
                            since_ms = it.now_ms;
                            if (rx_count >= rx_total) begin
                                tally_records();
                                client_phase = PH_COMPLETE;
                                done         = 1'b1;
                            end
                        end
                    end
                end
            end
            MODE_TICK: begin
                elapsed = it.now_ms - since_ms;
                if ((client_phase == PH_WSESSION || client_phase == PH_WREAD ||
                     client_phase == PH_WCF) && elapsed > timeout_reg) begin
                    client_phase = PH_ERROR;
                end
            end
            default: clear_transfer();
        endcase

        r              = '0;
        r.accepted     = tx_v;
        r.fsm_state    = client_phase;
        r.tx_valid     = tx_v;
        r.tx_dlc       = tx_len;
        r.tx_data      = tx_bytes;
        r.code_count   = 5'(record_count);
        r.last         = !(done && record_count > 0);
        results_due.push_back(r);
        if (done) begin
            for (k = 0; k < record_count; k++) begin
                off            = 3 + 4 * k;
                r              = '0;
                r.fsm_state    = client_phase;
                r.code_count   = 5'(record_count);
                r.record_valid = 1'b1;
                r.fault_code   = {rx_store[off], rx_store[off + 1], rx_store[off + 2]};
                r.fault_status = rx_store[off + 3];
                r.last         = (k == record_count - 1);
                results_due.push_back(r);
            end
        end
    endtask

    task automatic compare_result(input out_item_t got, input out_item_t want);
        string diffs;
        diffs = "";
        if (got.accepted !== want.accepted)
            diffs = {diffs, $sformatf(" accepted %0h/%0h", want.accepted, got.accepted)};
        if (got.fsm_state !== want.fsm_state)
            diffs = {diffs, $sformatf(" fsm_state %0d/%0d", want.fsm_state, got.fsm_state)};
        if (got.tx_valid !== want.tx_valid)
            diffs = {diffs, $sformatf(" tx_valid %0h/%0h", want.tx_valid, got.tx_valid)};
        if (got.tx_dlc !== want.tx_dlc)
            diffs = {diffs, $sformatf(" tx_dlc %0d/%0d", want.tx_dlc, got.tx_dlc)};
        if (got.tx_data !== want.tx_data)
            diffs = {diffs, $sformatf(" tx_data %h/%h", want.tx_data, got.tx_data)};
        if (got.code_count !== want.code_count)
            diffs = {diffs, $sformatf(" code_count %0d/%0d", want.code_count, got.code_count)};
        if (got.record_valid !== want.record_valid)
            diffs = {diffs, $sformatf(" record_valid %0h/%0h", want.record_valid,
                                      got.record_valid)};
        if (got.fault_code !== want.fault_code)
            diffs = {diffs, $sformatf(" fault_code %h/%h", want.fault_code, got.fault_code)};
        if (got.fault_status !== want.fault_status)
            diffs = {diffs, $sformatf(" fault_status %h/%h", want.fault_status,
                                      got.fault_status)};
        if (got.last !== want.last)
            diffs = {diffs, $sformatf(" last %0h/%0h", want.last, got.last)};
        if (diffs != "") begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] result mismatch, expected/actual:%s", $time, diffs);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_transfer();
            resp_filter_reg = '0;
            timeout_reg     = TIMEOUT_RESET;
            results_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_RESPONSE_ID: resp_filter_reg = cfg_data[28:0];
                    CFG_TIMEOUT_MS:  timeout_reg     = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_client_step(s_item);
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] result with none outstanding: %p", $time, m_item);
                end else begin
                    compare_result(m_item, results_due.pop_front());
                end
            end
        end
        pending <= results_due.size();
    end

endmodule

[tb/tb_uds_dtc_read_isotp_client.sv]
`timescale 1ns / 1ps
// Top of the fault-code read client testbench: clock, reset, register writes,
// frame stimulus and verdict. Needs udsdtc_pkg, the client RTL and dtc_read_checker.

module tb_uds_dtc_read_isotp_client;
    import udsdtc_pkg::*;

    localparam logic [63:0] SESSION_REPLY = 64'h0000_0000_0003_5002;
    localparam int          SETTLE_CYCLES = 150;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    in_item_t    s_item    = '0;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_ready;
    logic        m_valid;
    logic        cfg_ready;
    out_item_t   m_item;

    int          fail_count;
    int          pending;

    logic [28:0] resp_id      = '0;
    logic [31:0] limit_ms     = TIMEOUT_RESET;
    logic [31:0] clock_ms     = '0;
    bit          stall_enable = 1'b1;
    bit          drift        = 1'b0;
    int          gap_pct      = 20;
    int          stall_pct    = 20;
    int          driven_items = 0;

    always #5 aclk = ~aclk;

    uds_dtc_read_isotp_client i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dtc_read_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [28:0] req, input logic [28:0] resp,
                             input logic [31:0] tmo);
        resp_id  = resp;
        limit_ms = tmo;
        write_reg(CFG_REQUEST_ID, {3'b000, req});
        write_reg(CFG_RESPONSE_ID, {3'b000, resp});
        write_reg(CFG_TIMEOUT_MS, tmo);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic in_item_t make_item(input logic [1:0] mode, input logic [28:0] id,
                                           input logic ext, input logic [3:0] dlc,
                                           input logic [63:0] data);
        in_item_t it;
        it.mode           = mode;
        it.now_ms         = clock_ms;
        it.frame_id       = id;
        it.frame_extended = ext;
        it.frame_dlc      = dlc;
        it.frame_data     = data;
        return it;
    endfunction

    task automatic push_item(input in_item_t it);
        if (stall_enable && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge aclk);
        end
        if (drift) clock_ms += 32'($urandom_range(50));
        it.now_ms = clock_ms;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_ctl(input logic [1:0] mode);
        push_item(make_item(mode, 29'($urandom), 1'($urandom), 4'($urandom),
                            {$urandom, $urandom}));
        driven_items++;
    endtask

    task automatic send_frame(input logic [3:0] dlc, input logic [63:0] data);
        push_item(make_item(MODE_FRAME, resp_id, 1'b1, dlc, data));
        driven_items++;
    endtask

    // noise, stray ticks, timeouts and negative replies between regular frames
    task automatic maybe_disturb();
        logic [63:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(39))
            0, 1: begin
                d[7:4] = 4'($urandom_range(3));
                push_item(make_item(2'($urandom),
                                    ($urandom_range(3) == 0) ? 29'($urandom) : resp_id,
                                    1'($urandom_range(3) != 0), 4'($urandom), d));
            end
            2, 3: send_ctl(MODE_TICK);
            4: begin
                clock_ms += limit_ms + 32'd1;
                send_ctl(MODE_TICK);
            end
            5: begin
                d[15:8] = SID_NEGATIVE;
                send_frame(4'($urandom_range(15, 3)), d);
            end
            default: ;
        endcase
    endtask

    task automatic read_exchange();
        logic [63:0] d;
        logic [3:0]  dlc;
        logic [3:0]  seq;
        int          total;
        int          got;
        int          dlc8;
        gap_pct = stall_enable ? 25 * $urandom_range(2) : 0;
        if ($urandom_range(4) == 0) clock_ms = $urandom;
        if ($urandom_range(9) < 7) send_ctl(MODE_REINIT);
        send_ctl(MODE_START);
        maybe_disturb();
        d = {$urandom, $urandom};
        d[23:0] = {SESSION_EXT, SID_SESSION_POS, 8'h02};
        send_frame(4'($urandom_range(15, 3)), d);
        maybe_disturb();
        d = {$urandom, $urandom};
        if ($urandom_range(3) == 0) begin
            d[23:0] = {SUBFN_BY_MASK, SID_READ_POS, FT_SINGLE, 4'($urandom_range(15, 3))};
            send_frame(4'($urandom_range(15, 4)), d);
        end else begin
            case ($urandom_range(9))
                0:       total = $urandom_range(4095, 129);
                1, 2:    total = $urandom_range(128, 41);
                default: total = $urandom_range(40);
            endcase
            d[15:0] = {total[7:0], FT_FIRST, total[11:8]};
            send_frame(($urandom_range(3) == 0) ? 4'($urandom) : 4'd8, d);
            if (total > RX_BYTES_DEF) total = RX_BYTES_DEF;
            got = (total < 6) ? total : 6;
            seq = 4'd1;
            do begin
                maybe_disturb();
                dlc = ($urandom_range(3) == 0) ? 4'($urandom) : 4'd8;
                d = {$urandom, $urandom};
                d[7:0] = {FT_CONSEC, seq};
                if ($urandom_range(49) == 0) d[3:0] = seq + 4'($urandom_range(15, 1));
                send_frame(dlc, d);
                dlc8 = (dlc > 4'd8) ? 8 : int'(dlc);
                if (dlc8 > 1) got += dlc8 - 1;
                seq++;
            end while (got < total);
        end
        maybe_disturb();
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if ($urandom_range(15) == 0) stall_pct = 20 * $urandom_range(3);
            if (stall_enable && $urandom_range(99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(19, 1)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(40, 1)) @(posedge aclk);
        end
    end

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        configure(29'h18DA_10F1, 29'h18DA_F110, TIMEOUT_RESET);

        // negative reply in idle, then start and tick ignored in error
        send_ctl(MODE_REINIT);
        send_ctl(MODE_TICK);
        send_frame(4'd3, 64'h0000_0000_0011_7F03);
        send_ctl(MODE_TICK);
        send_ctl(MODE_START);
        send_ctl(MODE_REINIT);
        send_ctl(MODE_START);
        send_ctl(MODE_START);
        // foreign frames: standard identifier, then wrong identifier
        push_item(make_item(MODE_FRAME, resp_id, 1'b0, 4'd3, SESSION_REPLY));
        push_item(make_item(MODE_FRAME, resp_id ^ 29'h1, 1'b1, 4'd3, SESSION_REPLY));
        send_frame(4'd3, SESSION_REPLY);
        send_frame(4'd8, 64'h8877_6655_4433_2221);
        send_frame(4'd8, 64'h0000_0000_0003_5907);
        send_frame(4'd15, 64'hEEDD_CCBB_AA02_5907);
        send_ctl(MODE_TICK);
        send_ctl(MODE_REINIT);
        clock_ms = 32'hFFFF_FFF0;
        send_ctl(MODE_START);
        send_frame(4'd3, SESSION_REPLY);
        clock_ms += TIMEOUT_RESET;
        send_ctl(MODE_TICK);
        send_frame(4'd8, 64'h4433_2211_0259_0310);
        send_frame(4'd8, 64'hFFFF_FFFF_FFFF_FF21);
        send_ctl(MODE_REINIT);
        send_ctl(MODE_START);
        send_frame(4'd3, SESSION_REPLY);
        clock_ms += TIMEOUT_RESET + 32'd1;
        send_ctl(MODE_TICK);

        drift = 1'b1;
        for (int p = 0; p < 4; p++) begin
            if (p > 0) begin
                s_valid <= 1'b0;
                drain();
                case (p)
                    1: configure('0, '0, '0);
                    2: configure(29'h1FFF_FFFF, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
                    default: configure(29'($urandom), 29'($urandom), $urandom_range(5000, 100));
                endcase
            end
            stall_enable = (p != 3);
            target = driven_items + 100;
            while (driven_items < target) read_exchange();
        end
        s_valid <= 1'b0;
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/udsdtc_pkg.sv
src/udsdtc_ram.sv
src/udsdtc_front.sv
src/udsdtc_cmd_queue.sv
src/udsdtc_back.sv
src/uds_dtc_read_isotp_client.sv
tb/dtc_read_checker.sv
tb/tb_uds_dtc_read_isotp_client.sv
